// ----- sv/iddo_pkg.sv -----
// Shared types, codes and the rectangle side classifier of the depth-order table.
// Depends on nothing; iddo_ctrl, the top level and the testbench import it.
package iddo_pkg;

    localparam int POS_W = 7;
    localparam int ID_W  = 16;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LIST   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic        [14:0] size_h;
        logic        [14:0] size_w;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_x;
    } rect_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        rect_t           rect;
    } entry_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] order_pos;
        logic [ID_W-1:0]  out_id;
        logic             last;
    } rsp_t;

    // +1 when the new span starts at or past the stored far edge,
    // -1 when it ends at or before the stored near edge, else 0.
    function automatic logic signed [1:0] axis_side(
        logic signed [15:0] s_lo,
        logic        [14:0] s_len,
        logic signed [15:0] n_lo,
        logic        [14:0] n_len
    );
        logic signed [17:0] sl;
        logic signed [17:0] nl;
        logic signed [17:0] s_hi;
        logic signed [17:0] n_hi;
        sl   = 18'(s_lo);
        nl   = 18'(n_lo);
        s_hi = sl + signed'(18'({1'b0, s_len}));
        n_hi = nl + signed'(18'({1'b0, n_len}));
        if (nl >= s_hi) begin
            return 2'sd1;
        end else if (n_hi <= sl) begin
            return -2'sd1;
        end
        return 2'sd0;
    endfunction

    function automatic logic signed [2:0] side_of(rect_t stored, rect_t fresh);
        logic signed [1:0] sx;
        logic signed [1:0] sy;
        sx = axis_side(stored.pos_x, stored.size_w, fresh.pos_x, fresh.size_w);
        sy = axis_side(stored.pos_y, stored.size_h, fresh.pos_y, fresh.size_h);
        return 3'(sx) + 3'(sy);
    endfunction

endpackage

// ----- sv/iddo_intf.sv -----
// Valid/ready channel interfaces of the depth-order table: command and result.
// Standalone; widths follow the field list of the block.
interface iddo_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        size_w;
    logic [14:0]        size_h;
    logic [15:0]        entry_id;

    modport source (output valid, cmd, pos_x, pos_y, size_w, size_h, entry_id,
                    input ready);
    modport sink   (input valid, cmd, pos_x, pos_y, size_w, size_h, entry_id,
                    output ready);
endinterface

interface iddo_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [6:0]  order_pos;
    logic [15:0] out_id;
    logic        last;

    modport source (output valid, status, order_pos, out_id, last, input ready);
    modport sink   (input valid, status, order_pos, out_id, last, output ready);
endinterface

// ----- sv/iddo_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module iddo_ram #(
    parameter int WIDTH = 78,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/iddo_ctrl.sv -----
// Sequencer of the depth-order table: scans the table RAM, splits it through
// the scratch RAM on insert, shifts on remove and streams list results.
// Depends on iddo_pkg and iddo_intf.
module iddo_ctrl #(
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    iddo_req_if.sink                 req,
    output logic                     main_we,
    output logic [$clog2(DEPTH)-1:0] main_waddr,
    output iddo_pkg::entry_t         main_wdata,
    output logic [$clog2(DEPTH)-1:0] main_raddr,
    input  iddo_pkg::entry_t         main_rdata,
    output logic                     scr_we,
    output logic [$clog2(DEPTH)-1:0] scr_waddr,
    output iddo_pkg::entry_t         scr_wdata,
    output logic [$clog2(DEPTH)-1:0] scr_raddr,
    input  iddo_pkg::entry_t         scr_rdata,
    output logic                     res_push,
    output iddo_pkg::rsp_t           res,
    input  logic                     res_free
);

    import iddo_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_CHK  = 10'b00_0000_0010,
        S_DEC  = 10'b00_0000_0100,
        S_APP  = 10'b00_0000_1000,
        S_PASS = 10'b00_0001_0000,
        S_NEW  = 10'b00_0010_0000,
        S_BACK = 10'b00_0100_0000,
        S_REM  = 10'b00_1000_0000,
        S_LIST = 10'b01_0000_0000,
        S_RESP = 10'b10_0000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   pidx_reg, pidx_next;
    logic [CW-1:0]   wp_reg, wp_next;
    logic [CW-1:0]   bp_reg, bp_next;
    logic            rv_reg, rv_next;
    logic            back_seen_reg, back_seen_next;
    logic            found_reg, found_next;
    logic [1:0]      stat_reg, stat_next;
    rect_t           rect_reg, rect_next;
    logic [ID_W-1:0] id_reg, id_next;

    logic [CW-1:0]   idx_inc;
    logic [CW-1:0]   prev_idx;
    logic [CW-1:0]   last_idx;
    logic signed [2:0] side;
    logic            issue;
    logic            adv;
    logic            to_back;
    entry_t          fresh;

    assign idx_inc  = idx_reg + CW'(1);
    assign prev_idx = pidx_reg - CW'(1);
    assign last_idx = cnt_reg - CW'(1);
    assign side     = side_of(main_rdata.rect, rect_reg);
    assign to_back  = (side > 3'sd0) || ((side == 3'sd0) && back_seen_reg);
    assign fresh    = '{id: id_reg, rect: rect_reg};
    assign adv      = rv_reg && res_free;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pidx_next      = idx_reg;
        wp_next        = wp_reg;
        bp_next        = bp_reg;
        rv_next        = 1'b0;
        back_seen_next = back_seen_reg;
        found_next     = found_reg;
        stat_next      = stat_reg;
        rect_next      = rect_reg;
        id_next        = id_reg;
        issue          = 1'b0;
        main_we        = 1'b0;
        main_waddr     = wp_reg[AW-1:0];
        main_wdata     = fresh;
        main_raddr     = idx_reg[AW-1:0];
        scr_we         = 1'b0;
        scr_waddr      = bp_reg[AW-1:0];
        scr_wdata      = main_rdata;
        scr_raddr      = idx_reg[AW-1:0];
        res_push       = 1'b0;
        res            = '{status: stat_reg, order_pos: '0, out_id: id_reg, last: 1'b1};

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rect_next      = '{size_h: req.size_h, size_w: req.size_w,
                                       pos_y: req.pos_y, pos_x: req.pos_x};
                    id_next        = req.entry_id;
                    idx_next       = '0;
                    wp_next        = '0;
                    bp_next        = '0;
                    back_seen_next = 1'b0;
                    found_next     = 1'b0;
                    case (req.cmd)
                        CMD_INSERT:
                        begin
                            if (cnt_reg >= CW'(DEPTH))
                            begin
                                stat_next  = ST_FULL;
                                state_next = S_RESP;
                            end else if (cnt_reg == '0)
                            begin
                                state_next = S_APP;
                            end else
                            begin
                                state_next = S_CHK;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            state_next = S_REM;
                        end
                        CMD_LIST:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next  = ST_EMPTY;
                                id_next    = '0;
                                state_next = S_RESP;
                            end else
                            begin
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_CHK:
            begin
                main_raddr = last_idx[AW-1:0];
                state_next = S_DEC;
            end

            S_DEC:
            begin
                // A new rectangle in front of the last entry simply goes to the end.
                if (side < 3'sd0)
                begin
                    state_next = S_APP;
                end else
                begin
                    state_next = S_PASS;
                end
            end

            S_APP:
            begin
                main_we    = 1'b1;
                main_waddr = cnt_reg[AW-1:0];
                cnt_next   = cnt_reg + CW'(1);
                stat_next  = ST_OK;
                state_next = S_RESP;
            end

            S_PASS:
            begin
                // Front entries are compacted in place; the write pointer never
                // passes the read pointer. Back entries park in the scratch RAM.
                issue = (idx_reg < cnt_reg);
                if (issue)
                begin
                    idx_next = idx_inc;
                    rv_next  = 1'b1;
                end
                if (rv_reg)
                begin
                    if (side > 3'sd0)
                    begin
                        back_seen_next = 1'b1;
                    end
                    if (to_back)
                    begin
                        scr_we  = 1'b1;
                        bp_next = bp_reg + CW'(1);
                    end else
                    begin
                        main_we    = 1'b1;
                        main_wdata = main_rdata;
                        wp_next    = wp_reg + CW'(1);
                    end
                end
                if (!issue)
                begin
                    state_next = S_NEW;
                end
            end

            S_NEW:
            begin
                main_we    = 1'b1;
                wp_next    = wp_reg + CW'(1);
                idx_next   = '0;
                state_next = S_BACK;
            end

            S_BACK:
            begin
                issue = (idx_reg < bp_reg);
                if (issue)
                begin
                    idx_next = idx_inc;
                    rv_next  = 1'b1;
                end
                if (rv_reg)
                begin
                    main_we    = 1'b1;
                    main_wdata = scr_rdata;
                    wp_next    = wp_reg + CW'(1);
                end
                if (!issue)
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    stat_next  = ST_OK;
                    state_next = S_RESP;
                end
            end

            S_REM:
            begin
                // After the match every later entry moves down by one.
                issue = (idx_reg < cnt_reg);
                if (issue)
                begin
                    idx_next = idx_inc;
                    rv_next  = 1'b1;
                end
                if (rv_reg)
                begin
                    if (found_reg)
                    begin
                        main_we    = 1'b1;
                        main_waddr = prev_idx[AW-1:0];
                        main_wdata = main_rdata;
                    end else if (main_rdata.id == id_reg)
                    begin
                        found_next = 1'b1;
                    end
                end
                if (!issue)
                begin
                    if (found_next)
                    begin
                        cnt_next  = last_idx;
                        stat_next = ST_OK;
                    end else
                    begin
                        stat_next = ST_NOT_FOUND;
                    end
                    state_next = S_RESP;
                end
            end

            S_LIST:
            begin
                // The read address runs one entry ahead whenever a result leaves.
                rv_next = 1'b1;
                if (adv)
                begin
                    main_raddr = idx_inc[AW-1:0];
                    idx_next   = idx_inc;
                    res_push   = 1'b1;
                    res        = '{status: ST_OK, order_pos: POS_W'(idx_inc),
                                   out_id: main_rdata.id, last: (idx_inc == cnt_reg)};
                    if (idx_inc == cnt_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_RESP:
            begin
                if (res_free)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            pidx_reg      <= '0;
            wp_reg        <= '0;
            bp_reg        <= '0;
            rv_reg        <= 1'b0;
            back_seen_reg <= 1'b0;
            found_reg     <= 1'b0;
        end else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            pidx_reg      <= pidx_next;
            wp_reg        <= wp_next;
            bp_reg        <= bp_next;
            rv_reg        <= rv_next;
            back_seen_reg <= back_seen_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stat_reg <= stat_next;
        rect_reg <= rect_next;
        id_reg   <= id_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count exceeds table depth");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!main_we && !scr_we))
        else $error("RAM write while idle");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> res_free)
        else $error("result pushed into a full output stage");

    a_list_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST && res_push && !res.last) |=> (state_reg == S_LIST))
        else $error("list stream ended before its last entry");

    a_front_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PASS && main_we) |-> (wp_reg <= pidx_reg))
        else $error("compaction write overtook the scan");

endmodule

// ----- sv/isometric_depth_order_insert_top.sv -----
// Top level of the isometric depth-order table: RAMs, sequencer, output stage.
// Depends on iddo_pkg, iddo_intf, iddo_ram and iddo_ctrl.
//
//  Channel | Role  | Payload
//  --------+-------+---------------------------------------------------
//  req     | sink  | cmd, pos_x, pos_y, size_w, size_h, entry_id
//  rsp     | source| status, order_pos, out_id, last
//
// One command is handled at a time; req.ready is high only while idle.
// Insert: a scan of the table RAM that parks the entries behind the new one in
// the scratch RAM, then a copy back from it; an insert that lands at the end
// skips both. Remove: a single scan that shifts later entries down.
// List: one result per cycle while rsp is not stalled, after a first table read.
// Reset clears the count and control state; RAM contents are not cleared.
// A stalled rsp channel holds the output register and pauses the sequencer.
module isometric_depth_order_insert_top #(
    parameter int DEPTH = 32
) (
    input logic      clk,
    input logic      rst_n,
    iddo_req_if.sink req,
    iddo_rsp_if.source rsp
);

    import iddo_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int EW = $bits(entry_t);

    logic          main_we;
    logic [AW-1:0] main_waddr;
    entry_t        main_wdata;
    logic [AW-1:0] main_raddr;
    entry_t        main_rdata;
    logic          scr_we;
    logic [AW-1:0] scr_waddr;
    entry_t        scr_wdata;
    logic [AW-1:0] scr_raddr;
    entry_t        scr_rdata;
    logic          res_push;
    rsp_t          res;
    logic          res_free;

    logic          out_valid_reg, out_valid_next;
    rsp_t          out_data_reg;

    iddo_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_table_ram (
        .clk   (clk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (main_wdata),
        .raddr (main_raddr),
        .rdata (main_rdata)
    );

    iddo_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_scratch_ram (
        .clk   (clk),
        .we    (scr_we),
        .waddr (scr_waddr),
        .wdata (scr_wdata),
        .raddr (scr_raddr),
        .rdata (scr_rdata)
    );

    iddo_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .main_we    (main_we),
        .main_waddr (main_waddr),
        .main_wdata (main_wdata),
        .main_raddr (main_raddr),
        .main_rdata (main_rdata),
        .scr_we     (scr_we),
        .scr_waddr  (scr_waddr),
        .scr_wdata  (scr_wdata),
        .scr_raddr  (scr_raddr),
        .scr_rdata  (scr_rdata),
        .res_push   (res_push),
        .res        (res),
        .res_free   (res_free)
    );

    // The output register takes a new result in the same cycle the old one leaves.
    assign res_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_push)
        begin
            out_valid_next = 1'b1;
        end else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_data_reg.status;
    assign rsp.order_pos = out_data_reg.order_pos;
    assign rsp.out_id    = out_data_reg.out_id;
    assign rsp.last      = out_data_reg.last;

endmodule

// ----- tb/sv/isometric_depth_order_insert_top_tb.sv -----
// Self-checking testbench for isometric_depth_order_insert_top: directed table rows, then
// random command phases, checked against typed results or an in-bench draw-order model.
// Depends on iddo_pkg, iddo_intf and the block's RTL.
`timescale 1ns / 1ps

module isometric_depth_order_insert_top_tb;
    import iddo_pkg::*;

    localparam int         TABLE_DEPTH   = 32;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         STALL_LIMIT   = 4000;
    localparam int         SETTLE_CYCLES = 80;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0]        size_w;
        logic [14:0]        size_h;
        logic [15:0]        entry_id;
    } table_cmd_t;

    // A row with typed set carries its single result; other rows take their results from the model.
    typedef struct {
        logic [1:0]         cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0]        size_w;
        logic [14:0]        size_h;
        logic [15:0]        entry_id;
        bit                 typed;
        status_t            t_status;
        logic [15:0]        t_id;
    } directed_row_t;

    logic clk;
    logic rst_n;

    iddo_req_if req_ch ();
    iddo_rsp_if rsp_ch ();

    isometric_depth_order_insert_top #(
        .DEPTH (TABLE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Model of the draw-order table, back to front.
    rect_t       model_rect [TABLE_DEPTH];
    logic [15:0] model_id   [TABLE_DEPTH];
    int          model_count;
    rsp_t        pending_rsp_q [$];

    int sender_idle_pct;
    int receiver_idle_pct;
    bit hold_request;

    int mismatch_count;
    int results_checked;
    int stall_cycles;
    int n_insert;
    int n_remove;
    int n_list;
    int n_unused;
    int n_full;
    int n_miss;
    int peak_fill;

    directed_row_t directed_rows [20] = '{
        '{CMD_LIST,   16'sd0,     16'sd0,     15'd0,     15'd0,     16'h0000,
          1'b1, ST_EMPTY,     16'h0000},
        '{CMD_REMOVE, 16'sd0,     16'sd0,     15'd0,     15'd0,     16'h1234,
          1'b1, ST_NOT_FOUND, 16'h1234},
        '{CMD_INSERT, 16'sd0,     16'sd0,     15'd10,    15'd10,    16'h0001,
          1'b1, ST_OK,        16'h0001},
        '{CMD_INSERT, 16'sh8000,  16'sh8000,  15'd0,     15'd0,     16'h0000,
          1'b1, ST_OK,        16'h0000},
        '{CMD_INSERT, 16'sh7FFF,  16'sh7FFF,  15'h7FFF,  15'h7FFF,  16'hFFFF,
          1'b1, ST_OK,        16'hFFFF},
        '{CMD_INSERT, 16'sd20,    16'sd20,    15'd5,     15'd5,     16'h0002,
          1'b0, ST_OK,        16'h0000},
        '{CMD_INSERT, 16'sd5,     16'sd5,     15'd10,    15'd10,    16'h0003,
          1'b0, ST_OK,        16'h0000},
        '{CMD_INSERT, -16'sd20,   -16'sd20,   15'd5,     15'd5,     16'h0004,
          1'b0, ST_OK,        16'h0000},
        '{CMD_INSERT, 16'sd0,     16'sd30,    15'd5,     15'd5,     16'h0002,
          1'b0, ST_OK,        16'h0000},
        '{CMD_LIST,   16'sd0,     16'sd0,     15'd0,     15'd0,     16'h0000,
          1'b0, ST_OK,        16'h0000},
        '{CMD_REMOVE, 16'sd0,     16'sd0,     15'd0,     15'd0,     16'h0002,
          1'b1, ST_OK,        16'h0002},
        '{CMD_LIST,   16'sd0,     16'sd0,     15'd0,     15'd0,     16'h0000,
          1'b0, ST_OK,        16'h0000},
        '{CMD_UNUSED, 16'sh7FFF,  16'sh8000,  15'h7FFF,  15'h7FFF,  16'hFFFF,
          1'b0, ST_OK,        16'h0000},
        '{CMD_INSERT, 16'sd5,     16'sd5,     15'd0,     15'd0,     16'h0005,
          1'b0, ST_OK,        16'h0000},
        '{CMD_INSERT, 16'sh7FFF,  16'sh8000,  15'h7FFF,  15'd0,     16'h8000,
          1'b0, ST_OK,        16'h0000},
        '{CMD_REMOVE, 16'sd0,     16'sd0,     15'd0,     15'd0,     16'hFFFF,
          1'b1, ST_OK,        16'hFFFF},
        '{CMD_REMOVE, 16'sd0,     16'sd0,     15'd0,     15'd0,     16'hFFFF,
          1'b1, ST_NOT_FOUND, 16'hFFFF},
        '{CMD_LIST,   16'sd0,     16'sd0,     15'd0,     15'd0,     16'h0000,
          1'b0, ST_OK,        16'h0000},
        '{CMD_INSERT, 16'sh8000,  16'sh7FFF,  15'h7FFF,  15'h7FFF,  16'h7FFF,
          1'b0, ST_OK,        16'h0000},
        '{CMD_LIST,   16'sd0,     16'sd0,     15'd0,     15'd0,     16'h0000,
          1'b0, ST_OK,        16'h0000}
    };

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Int arithmetic keeps edge sums exact, so no sum can wrap.
    function automatic int span_order(int s_lo, int s_len, int n_lo, int n_len);
        if (n_lo >= s_lo + s_len)
        begin
            return 1;
        end
        if (n_lo + n_len <= s_lo)
        begin
            return -1;
        end
        return 0;
    endfunction

    function automatic int depth_side(rect_t held, rect_t fresh);
        return span_order(int'(held.pos_x), int'(held.size_w),
                          int'(fresh.pos_x), int'(fresh.size_w))
             + span_order(int'(held.pos_y), int'(held.size_h),
                          int'(fresh.pos_y), int'(fresh.size_h));
    endfunction

    task automatic apply_table_cmd(input table_cmd_t c, ref rsp_t outs[$]);
        rect_t       r;
        rect_t       front_r [TABLE_DEPTH];
        rect_t       back_r  [TABLE_DEPTH];
        logic [15:0] front_i [TABLE_DEPTH];
        logic [15:0] back_i  [TABLE_DEPTH];
        int          nf;
        int          nb;
        int          j;
        int          hit;
        int          s;
        bit          back_seen;
        r.pos_x  = c.pos_x;
        r.pos_y  = c.pos_y;
        r.size_w = c.size_w;
        r.size_h = c.size_h;
        outs = {};
        case (c.cmd)
            CMD_INSERT:
            begin
                if (model_count >= TABLE_DEPTH)
                begin
                    outs.push_back('{ST_FULL, 7'd0, c.entry_id, 1'b1});
                    n_full++;
                end
                else
                begin
                    if (model_count == 0 || depth_side(model_rect[model_count - 1], r) < 0)
                    begin
                        model_rect[model_count] = r;
                        model_id[model_count]   = c.entry_id;
                    end
                    else
                    begin
                        nf = 0;
                        nb = 0;
                        back_seen = 1'b0;
                        for (int i = 0; i < model_count; i++)
                        begin
                            s = depth_side(model_rect[i], r);
                            if (s > 0 || (s == 0 && back_seen))
                            begin
                                back_r[nb] = model_rect[i];
                                back_i[nb] = model_id[i];
                                nb++;
                            end
                            else
                            begin
                                front_r[nf] = model_rect[i];
                                front_i[nf] = model_id[i];
                                nf++;
                            end
                            if (s > 0)
                            begin
                                back_seen = 1'b1;
                            end
                        end
                        j = 0;
                        for (int i = 0; i < nf; i++)
                        begin
                            model_rect[j] = front_r[i];
                            model_id[j]   = front_i[i];
                            j++;
                        end
                        model_rect[j] = r;
                        model_id[j]   = c.entry_id;
                        j++;
                        for (int i = 0; i < nb; i++)
                        begin
                            model_rect[j] = back_r[i];
                            model_id[j]   = back_i[i];
                            j++;
                        end
                    end
                    model_count++;
                    if (model_count > peak_fill)
                    begin
                        peak_fill = model_count;
                    end
                    outs.push_back('{ST_OK, 7'd0, c.entry_id, 1'b1});
                end
            end
            CMD_REMOVE:
            begin
                hit = -1;
                for (int i = 0; i < model_count; i++)
                begin
                    if (hit < 0 && model_id[i] == c.entry_id)
                    begin
                        hit = i;
                    end
                end
                if (hit >= 0)
                begin
                    for (int i = hit; i + 1 < model_count; i++)
                    begin
                        model_rect[i] = model_rect[i + 1];
                        model_id[i]   = model_id[i + 1];
                    end
                    model_count--;
                    outs.push_back('{ST_OK, 7'd0, c.entry_id, 1'b1});
                end
                else
                begin
                    outs.push_back('{ST_NOT_FOUND, 7'd0, c.entry_id, 1'b1});
                    n_miss++;
                end
            end
            CMD_LIST:
            begin
                if (model_count == 0)
                begin
                    outs.push_back('{ST_EMPTY, 7'd0, 16'h0000, 1'b1});
                end
                for (int i = 0; i < model_count; i++)
                begin
                    outs.push_back('{ST_OK, 7'(i + 1), model_id[i], i + 1 == model_count});
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Mix 0 fills the table past full, mix 1 drains it, mix 2 leans toward inserts.
    function automatic table_cmd_t random_table_cmd(int mix);
        table_cmd_t c;
        int         pick;
        int         roll;
        int         ins_lim;
        int         rem_lim;
        pick    = int'($urandom_range(0, 99));
        ins_lim = (mix == 0) ? 88 : (mix == 1) ? 25 : 50;
        rem_lim = (mix == 0) ? 92 : 75;
        if (pick < ins_lim)
        begin
            c.cmd = CMD_INSERT;
        end
        else if (pick < rem_lim)
        begin
            c.cmd = CMD_REMOVE;
        end
        else if (pick < 97)
        begin
            c.cmd = CMD_LIST;
        end
        else
        begin
            c.cmd = CMD_UNUSED;
        end
        // Mostly small rectangles near the origin so that they overlap and interleave.
        if ($urandom_range(0, 4) == 0)
        begin
            c.pos_x  = 16'($urandom);
            c.pos_y  = 16'($urandom);
            c.size_w = 15'($urandom);
            c.size_h = 15'($urandom);
        end
        else
        begin
            c.pos_x  = 16'(int'($urandom_range(0, 80)) - 40);
            c.pos_y  = 16'(int'($urandom_range(0, 80)) - 40);
            c.size_w = 15'($urandom_range(0, 24));
            c.size_h = 15'($urandom_range(0, 24));
        end
        roll = int'($urandom_range(0, 19));
        if (roll < 12)
        begin
            c.entry_id = 16'($urandom_range(0, 15));
        end
        else if (roll == 12)
        begin
            c.entry_id = 16'hFFFF;
        end
        else if (roll == 13)
        begin
            c.entry_id = 16'h0000;
        end
        else
        begin
            c.entry_id = 16'($urandom);
        end
        if (c.cmd == CMD_REMOVE && model_count > 0 && $urandom_range(0, 9) < 7)
        begin
            c.entry_id = model_id[$urandom_range(0, model_count - 1)];
        end
        return c;
    endfunction

    task automatic offer_cmd(input table_cmd_t c);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= c.cmd;
        req_ch.pos_x    <= c.pos_x;
        req_ch.pos_y    <= c.pos_y;
        req_ch.size_w   <= c.size_w;
        req_ch.size_h   <= c.size_h;
        req_ch.entry_id <= c.entry_id;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
    endtask

    // Predictions are queued at the accepting edge; a result never leaves on that same edge.
    task automatic run_cmd(input table_cmd_t c, input bit typed, input rsp_t typed_rsp);
        rsp_t outs [$];
        offer_cmd(c);
        apply_table_cmd(c, outs);
        if (typed)
        begin
            outs = {typed_rsp};
        end
        foreach (outs[i])
        begin
            pending_rsp_q.push_back(outs[i]);
        end
        case (c.cmd)
            CMD_INSERT: n_insert++;
            CMD_REMOVE: n_remove++;
            CMD_LIST:   n_list++;
            default:    n_unused++;
        endcase
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        bit hold_done;
        hold_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done    = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                results_checked++;
                got = '{rsp_ch.status, rsp_ch.order_pos, rsp_ch.out_id, rsp_ch.last};
                if (pending_rsp_q.size() == 0)
                begin
                    $error("unexpected result transaction: status %0d pos %0d id %h last %0d",
                           got.status, got.order_pos, got.out_id, got.last);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_rsp_q.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatch_count++;
                    end
                    if (got.order_pos !== want.order_pos)
                    begin
                        $error("order_pos: expected %0d, got %0d", want.order_pos,
                               got.order_pos);
                        mismatch_count++;
                    end
                    if (got.out_id !== want.out_id)
                    begin
                        $error("out_id: expected %h, got %h", want.out_id, got.out_id);
                        mismatch_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        mismatch_count++;
                    end
                end
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: %0d cycles without a transaction, %0d results pending",
                         STALL_LIMIT, pending_rsp_q.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        table_cmd_t c;
        rsp_t       typed_rsp;
        int         phase_len;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.cmd      = CMD_INSERT;
        req_ch.pos_x    = '0;
        req_ch.pos_y    = '0;
        req_ch.size_w   = '0;
        req_ch.size_h   = '0;
        req_ch.entry_id = '0;
        model_count       = 0;
        hold_request      = 1'b0;
        sender_idle_pct   = 27;
        receiver_idle_pct = 85;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            c.cmd      = directed_rows[i].cmd;
            c.pos_x    = directed_rows[i].pos_x;
            c.pos_y    = directed_rows[i].pos_y;
            c.size_w   = directed_rows[i].size_w;
            c.size_h   = directed_rows[i].size_h;
            c.entry_id = directed_rows[i].entry_id;
            typed_rsp  = '{directed_rows[i].t_status, 7'd0, directed_rows[i].t_id, 1'b1};
            run_cmd(c, directed_rows[i].typed, typed_rsp);
        end
        wait_for_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct   = (phase == 0) ? 27 : (phase == 1) ? 85 : 0;
            receiver_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 27 : 0;
            phase_len         = (phase == 0) ? 40 : 30;
            for (int k = 0; k < phase_len; k++)
            begin
                // The long hold-off lets the output back up into the command channel.
                if (phase == 2 && k == 4)
                begin
                    hold_request = 1'b1;
                end
                run_cmd(random_table_cmd(phase), 1'b0, '0);
            end
            wait_for_results();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_rsp_q.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_rsp_q.size());
        end
        $display("Ran %0d commands: %0d inserts, %0d removes, %0d lists, %0d unused codes.",
                 n_insert + n_remove + n_list + n_unused, n_insert, n_remove, n_list,
                 n_unused);
        $display("Checked %0d results; table peaked at %0d of %0d, %0d full, %0d id misses.",
                 results_checked, peak_fill, TABLE_DEPTH, n_full, n_miss);
        if (mismatch_count == 0 && pending_rsp_q.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
